// File: hdl/resistor_ladder_button_debouncer_defines.svh
`ifndef RESISTOR_LADDER_BUTTON_DEBOUNCER_DEFINES_SVH
`define RESISTOR_LADDER_BUTTON_DEBOUNCER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define RLBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rlbd check failed");

// next-cycle implication, checked while out of reset
`define RLBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rlbd check failed");

`endif

// File: hdl/rlbd_pkg.sv
package rlbd_pkg;

	localparam int ADC_W     = 12;
	localparam int DEB_W     = 16;
	localparam int MS_W      = 32;
	localparam int MASK_W    = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	localparam int LADDER_A_KEYS_DEF = 4;
	localparam int LADDER_B_KEYS_DEF = 2;
	localparam int TIME_BITS_DEF     = 32;

	localparam logic [ADC_W-1:0] A_TOP_RST = 12'd3800;
	localparam logic [ADC_W-1:0] A_LVL1_RST = 12'd3100;
	localparam logic [ADC_W-1:0] A_LVL2_RST = 12'd2090;
	localparam logic [ADC_W-1:0] A_LVL3_RST = 12'd750;
	localparam logic [ADC_W-1:0] B_TOP_RST = 12'd3800;
	localparam logic [ADC_W-1:0] B_LVL1_RST = 12'd1120;
	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd5;

	typedef logic [MS_W-1:0]   ms_t;
	typedef logic [MASK_W-1:0] mask_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A_TOP    = 3'd0,
		REG_A_LVL1   = 3'd1,
		REG_A_LVL2   = 3'd2,
		REG_A_LVL3   = 3'd3,
		REG_B_TOP    = 3'd4,
		REG_B_LVL1   = 3'd5,
		REG_DEBOUNCE = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [ADC_W-1:0] adc_ladder_a;
		logic [ADC_W-1:0] adc_ladder_b;
		logic             power_pin_low;
		ms_t              now_ms;
	} item_t;

	typedef struct packed {
		mask_t held_mask;
		mask_t pressed_mask;
		mask_t released_mask;
		ms_t   held_time_ms;
	} result_t;

endpackage

// File: hdl/resistor_ladder_button_debouncer.sv
// Path: an accepted word is held in the input register and passes to the result register
// unless an earlier result is still waiting to be taken.
// Throughput: one word per cycle; an input register and a result register each hold
// one word, so one more word is taken in while a result waits, then input stalls.
// Reset (arst_n low, asynchronous): pipeline empty, debounce and gesture state zero,
// ladder thresholds and debounce time back to their default values.
`include "resistor_ladder_button_debouncer_defines.svh"

module resistor_ladder_button_debouncer #(
	parameter int LADDER_A_KEYS = rlbd_pkg::LADDER_A_KEYS_DEF,
	parameter int LADDER_B_KEYS = rlbd_pkg::LADDER_B_KEYS_DEF,
	parameter int TIME_BITS     = rlbd_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  rlbd_pkg::item_t                  item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output rlbd_pkg::result_t                result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rlbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rlbd_pkg::CFG_W-1:0]       cfg_data
);

	logic [rlbd_pkg::ADC_W-1:0] bnd_a_q [4];
	logic [rlbd_pkg::ADC_W-1:0] bnd_b_q [2];
	logic [rlbd_pkg::DEB_W-1:0] debounce_q;

	rlbd_pkg::item_t   item_s1;
	logic              valid_s1;
	rlbd_pkg::result_t result_q;
	logic              result_valid_q;

	rlbd_pkg::mask_t        last_raw_q;
	rlbd_pkg::mask_t        debounced_q;
	logic [TIME_BITS-1:0]   last_change_q;
	logic [TIME_BITS-1:0]   start_q;
	logic [TIME_BITS-1:0]   end_q;

	logic                   advance;
	logic [3:0]             band_a;
	logic [1:0]             band_b;
	logic [3:0]             raw_a;
	logic [1:0]             raw_b;
	rlbd_pkg::mask_t        raw;
	logic [TIME_BITS-1:0]   now_t;
	logic [TIME_BITS-1:0]   change_ms;
	logic [TIME_BITS-1:0]   stable_ms;
	logic                   take;
	rlbd_pkg::mask_t        pressed;
	rlbd_pkg::mask_t        released;
	rlbd_pkg::mask_t        deb_next;
	logic [TIME_BITS-1:0]   start_next;
	logic [TIME_BITS-1:0]   end_next;
	logic [TIME_BITS-1:0]   held_t;

	// handshake
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_a_q[0] <= rlbd_pkg::A_TOP_RST;
			bnd_a_q[1] <= rlbd_pkg::A_LVL1_RST;
			bnd_a_q[2] <= rlbd_pkg::A_LVL2_RST;
			bnd_a_q[3] <= rlbd_pkg::A_LVL3_RST;
			bnd_b_q[0] <= rlbd_pkg::B_TOP_RST;
			bnd_b_q[1] <= rlbd_pkg::B_LVL1_RST;
			debounce_q <= rlbd_pkg::DEBOUNCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rlbd_pkg::cfg_reg_t'(cfg_index))
				rlbd_pkg::REG_A_TOP:    bnd_a_q[0] <= cfg_data[rlbd_pkg::ADC_W-1:0];
				rlbd_pkg::REG_A_LVL1:   bnd_a_q[1] <= cfg_data[rlbd_pkg::ADC_W-1:0];
				rlbd_pkg::REG_A_LVL2:   bnd_a_q[2] <= cfg_data[rlbd_pkg::ADC_W-1:0];
				rlbd_pkg::REG_A_LVL3:   bnd_a_q[3] <= cfg_data[rlbd_pkg::ADC_W-1:0];
				rlbd_pkg::REG_B_TOP:    bnd_b_q[0] <= cfg_data[rlbd_pkg::ADC_W-1:0];
				rlbd_pkg::REG_B_LVL1:   bnd_b_q[1] <= cfg_data[rlbd_pkg::ADC_W-1:0];
				rlbd_pkg::REG_DEBOUNCE: debounce_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// band compares: strict lower, inclusive upper; last band of a ladder has no floor
	for (genvar i = 0; i < 4; i++) begin : g_band_a
		if (i == 3) begin : g_last
			assign band_a[i] = item_s1.adc_ladder_a <= bnd_a_q[i];
		end else begin : g_mid
			assign band_a[i] = (item_s1.adc_ladder_a > bnd_a_q[i+1]) &&
				(item_s1.adc_ladder_a <= bnd_a_q[i]);
		end
	end

	assign band_b[0] = (item_s1.adc_ladder_b > bnd_b_q[1]) &&
		(item_s1.adc_ladder_b <= bnd_b_q[0]);
	assign band_b[1] = item_s1.adc_ladder_b <= bnd_b_q[1];

	// first matching band wins, only the configured keys are tried
	always_comb begin
		logic found_a;
		logic found_b;
		raw_a   = '0;
		raw_b   = '0;
		found_a = 1'b0;
		found_b = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (i < LADDER_A_KEYS && !found_a && band_a[i]) begin
				raw_a[i] = 1'b1;
				found_a  = 1'b1;
			end
		end
		for (int i = 0; i < 2; i++) begin
			if (i < LADDER_B_KEYS && !found_b && band_b[i]) begin
				raw_b[i] = 1'b1;
				found_b  = 1'b1;
			end
		end
	end

	assign raw   = {item_s1.power_pin_low, raw_b, raw_a};
	assign now_t = item_s1.now_ms[TIME_BITS-1:0];

	// a raw change restarts the stable time at zero
	assign change_ms = (raw != last_raw_q) ? now_t : last_change_q;
	assign stable_ms = now_t - change_ms;
	assign take      = (stable_ms > TIME_BITS'(debounce_q)) && (raw != debounced_q);

	always_comb begin
		pressed    = '0;
		released   = '0;
		deb_next   = debounced_q;
		start_next = start_q;
		end_next   = end_q;
		if (take) begin
			pressed  = raw & ~debounced_q;
			released = debounced_q & ~raw;
			deb_next = raw;
			if (pressed != '0 && debounced_q == '0) begin
				start_next = now_t;
			end
			if (released != '0 && raw == '0) begin
				end_next = now_t;
			end
		end
	end

	assign held_t = (deb_next != '0) ? (now_t - start_next) : (end_next - start_next);

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q     <= '0;
			last_change_q  <= '0;
			debounced_q    <= '0;
			start_q        <= '0;
			end_q          <= '0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			last_raw_q     <= raw;
			last_change_q  <= change_ms;
			debounced_q    <= deb_next;
			start_q        <= start_next;
			end_q          <= end_next;
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.held_mask     <= deb_next;
			result_q.pressed_mask  <= pressed;
			result_q.released_mask <= released;
			result_q.held_time_ms  <= rlbd_pkg::ms_t'(held_t);
		end
	end

	`RLBD_ASSERT_NOW(a_press_release_disjoint, clk, arst_n, result_valid_q,
		(result_q.pressed_mask & result_q.released_mask) == '0)
	`RLBD_ASSERT_NOW(a_pressed_is_held, clk, arst_n, result_valid_q,
		(result_q.pressed_mask & ~result_q.held_mask) == '0)
	`RLBD_ASSERT_NOW(a_released_not_held, clk, arst_n, result_valid_q,
		(result_q.released_mask & result_q.held_mask) == '0)
	`RLBD_ASSERT_NEXT(a_advance_gives_result, clk, arst_n, advance, result_valid_q)
	`RLBD_ASSERT_NEXT(a_state_only_on_advance, clk, arst_n, !advance,
		$stable(debounced_q) && $stable(last_raw_q))

endmodule
